>>> hdl/saabb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package saabb_pkg;

   localparam int unsigned CoordW = 24;
   localparam int unsigned SizeW  = 23;
   localparam int unsigned GapW   = 26;
   localparam int unsigned QuoW   = 18;
   localparam int unsigned FracW  = 16;
   localparam int unsigned RemW   = GapW + FracW;
   localparam int unsigned TimeW  = 20;
   localparam int unsigned DivSteps = QuoW;
   localparam int unsigned Lanes  = 4;

   // lane codes
   localparam int unsigned LaneXIn  = 0;
   localparam int unsigned LaneXOut = 1;
   localparam int unsigned LaneYIn  = 2;
   localparam int unsigned LaneYOut = 3;

   localparam logic signed [TimeW-1:0] TimeOne = 20'sd65536;
   localparam logic signed [TimeW-1:0] TimeSat = 20'sd131072;
   localparam logic signed [TimeW-1:0] TimeInf = 20'sd262144;
   localparam logic [QuoW-1:0]         QuoSat  = 18'd131072;

   localparam logic signed [1:0] NormPos  = 2'sb01;
   localparam logic signed [1:0] NormNeg  = 2'sb11;
   localparam logic signed [1:0] NormNone = 2'sb00;

   typedef struct packed {
      logic [RemW-1:0]   rem;
      logic [CoordW-1:0] den;
      logic [QuoW-1:0]   quo;
      logic              neg;
      logic              sat;
   } div_type;

   typedef struct packed {
      logic gx_neg;
      logic gy_neg;
      logic vx_zero;
      logic vy_zero;
   } side_type;

endpackage
`default_nettype wire

>>> hdl/swept_aabb_collision_time.sv
`timescale 1ns / 1ps
`default_nettype none
// Stages from the accepting start edge to rsp_strobe: gap stage, magnitude stage, 18 restoring divide
// stages of one quotient bit each, time stage, result stage.
// Throughput: one transaction every cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous, active high; clears every pipeline valid bit, payload is not cleared.
module swept_aabb_collision_time (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic signed [23:0]  req_mover_x,
   input  wire logic signed [23:0]  req_mover_y,
   input  wire logic        [22:0]  req_mover_w,
   input  wire logic        [22:0]  req_mover_h,
   input  wire logic signed [23:0]  req_mover_vx,
   input  wire logic signed [23:0]  req_mover_vy,
   input  wire logic signed [23:0]  req_fixed_x,
   input  wire logic signed [23:0]  req_fixed_y,
   input  wire logic        [22:0]  req_fixed_w,
   input  wire logic        [22:0]  req_fixed_h,
   output logic                     rsp_strobe,
   output logic             [16:0]  rsp_hit_time,
   output logic signed      [1:0]   rsp_normal_x,
   output logic signed      [1:0]   rsp_normal_y
);

   localparam int unsigned GW = saabb_pkg::GapW;
   localparam int unsigned CW = saabb_pkg::CoordW;
   localparam int unsigned TW = saabb_pkg::TimeW;
   localparam int unsigned NS = saabb_pkg::DivSteps;
   localparam int unsigned NL = saabb_pkg::Lanes;

   // the pipeline never holds off a transaction
   assign busy = 1'b0;

   // ---------------- gap stage ----------------
   logic                 v1_ff;
   logic signed [GW-1:0] gap_ff [NL];
   logic signed [CW-1:0] vx_ff, vy_ff;
   logic signed [GW-1:0] gap_in [NL];

   always_comb begin
      logic signed [GW-1:0] mx, my, mw, mh, fx, fy, fw, fh;
      logic signed [GW-1:0] xa, xb, ya, yb;
      mx = GW'(req_mover_x);
      my = GW'(req_mover_y);
      fx = GW'(req_fixed_x);
      fy = GW'(req_fixed_y);
      mw = $signed({3'b000, req_mover_w});
      mh = $signed({3'b000, req_mover_h});
      fw = $signed({3'b000, req_fixed_w});
      fh = $signed({3'b000, req_fixed_h});
      // a: static low edge - mover high edge; b: static high edge - mover low edge
      xa = fx - (mx + mw);
      xb = (fx + fw) - mx;
      ya = fy - (my + mh);
      yb = (fy + fh) - my;
      // pick near and far gaps by the direction of motion
      if (req_mover_vx > 0) begin
         gap_in[saabb_pkg::LaneXIn]  = xa;
         gap_in[saabb_pkg::LaneXOut] = xb;
      end else begin
         gap_in[saabb_pkg::LaneXIn]  = xb;
         gap_in[saabb_pkg::LaneXOut] = xa;
      end
      if (req_mover_vy > 0) begin
         gap_in[saabb_pkg::LaneYIn]  = ya;
         gap_in[saabb_pkg::LaneYOut] = yb;
      end else begin
         gap_in[saabb_pkg::LaneYIn]  = yb;
         gap_in[saabb_pkg::LaneYOut] = ya;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      vx_ff <= req_mover_vx;
      vy_ff <= req_mover_vy;
      for (int l = 0; l < NL; l++) begin
         gap_ff[l] <= gap_in[l];
      end
   end

   // ---------------- magnitude stage ----------------
   // Divide magnitudes; take the sign apart so that truncation runs toward zero.
   saabb_pkg::div_type  dv_ff   [NS+1][NL];
   saabb_pkg::side_type sd_ff   [NS+1];
   logic                vd_ff   [NS+1];
   saabb_pkg::div_type  dv0_in  [NL];
   saabb_pkg::div_type  dvs_in  [NS][NL];

   always_comb begin
      logic signed [CW-1:0] vel;
      logic [GW-1:0]        num;
      logic [CW-1:0]        den;
      for (int l = 0; l < NL; l++) begin
         vel = (l < 2) ? vx_ff : vy_ff;
         num = gap_ff[l][GW-1] ? GW'(-gap_ff[l]) : GW'(gap_ff[l]);
         den = vel[CW-1] ? CW'(-vel) : CW'(vel);
         dv0_in[l].rem = {num, {saabb_pkg::FracW{1'b0}}};
         dv0_in[l].den = den;
         dv0_in[l].quo = '0;
         dv0_in[l].neg = gap_ff[l][GW-1] ^ vel[CW-1];
         // quotient would not fit in the quotient bits: num >= den * 4
         dv0_in[l].sat = ({1'b0, num} >= {1'b0, den, 2'b00});
      end
   end

   // ---------------- divide stages: one quotient bit each, MSB first ----------------
   always_comb begin
      logic [saabb_pkg::RemW-1:0] sub;
      for (int k = 1; k <= NS; k++) begin
         for (int l = 0; l < NL; l++) begin
            dvs_in[k-1][l] = dv_ff[k-1][l];
            sub = saabb_pkg::RemW'(dv_ff[k-1][l].den) << (NS - k);
            if (dv_ff[k-1][l].rem >= sub) begin
               dvs_in[k-1][l].rem      = dv_ff[k-1][l].rem - sub;
               dvs_in[k-1][l].quo[NS-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v1_ff;
         for (int k = 1; k <= NS; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
      sd_ff[0].gx_neg  <= gap_ff[saabb_pkg::LaneXIn][GW-1];
      sd_ff[0].gy_neg  <= gap_ff[saabb_pkg::LaneYIn][GW-1];
      sd_ff[0].vx_zero <= (vx_ff == '0);
      sd_ff[0].vy_zero <= (vy_ff == '0);
      for (int l = 0; l < NL; l++) begin
         dv_ff[0][l] <= dv0_in[l];
      end
      for (int k = 1; k <= NS; k++) begin
         sd_ff[k] <= sd_ff[k-1];
         for (int l = 0; l < NL; l++) begin
            dv_ff[k][l] <= dvs_in[k-1][l];
         end
      end
   end

   // ---------------- time stage ----------------
   logic                 vt_ff;
   saabb_pkg::side_type  st_ff;
   logic signed [TW-1:0] t_ff [NL];
   logic signed [TW-1:0] t_in [NL];

   always_comb begin
      logic [saabb_pkg::QuoW-1:0] mag;
      logic                       vz;
      for (int l = 0; l < NL; l++) begin
         vz  = (l < 2) ? sd_ff[NS].vx_zero : sd_ff[NS].vy_zero;
         mag = (dv_ff[NS][l].sat || dv_ff[NS][l].quo > saabb_pkg::QuoSat)
               ? saabb_pkg::QuoSat : dv_ff[NS][l].quo;
         if (vz) begin
            // standing still on this axis: entry at minus, exit at plus infinity
            t_in[l] = (l == saabb_pkg::LaneXIn || l == saabb_pkg::LaneYIn)
                      ? -saabb_pkg::TimeInf : saabb_pkg::TimeInf;
         end else if (dv_ff[NS][l].neg) begin
            t_in[l] = -$signed({2'b00, mag});
         end else begin
            t_in[l] = $signed({2'b00, mag});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else begin
         vt_ff <= vd_ff[NS];
      end
      st_ff <= sd_ff[NS];
      for (int l = 0; l < NL; l++) begin
         t_ff[l] <= t_in[l];
      end
   end

   // ---------------- result stage ----------------
   logic                rsp_strobe_ff;
   logic        [16:0]  rsp_hit_time_ff, rsp_hit_time_in;
   logic signed [1:0]   rsp_normal_x_ff, rsp_normal_x_in;
   logic signed [1:0]   rsp_normal_y_ff, rsp_normal_y_in;

   always_comb begin
      logic signed [TW-1:0] xin, yin, xout, yout, entry, leave;
      logic                 miss;
      xin   = t_ff[saabb_pkg::LaneXIn];
      yin   = t_ff[saabb_pkg::LaneYIn];
      xout  = t_ff[saabb_pkg::LaneXOut];
      yout  = t_ff[saabb_pkg::LaneYOut];
      entry = (xin > yin) ? xin : yin;
      leave = (xout < yout) ? xout : yout;
      miss  = (entry > leave) || (xin < 0 && yin < 0) ||
              (xin > saabb_pkg::TimeOne) || (yin > saabb_pkg::TimeOne);
      if (miss) begin
         rsp_hit_time_in = saabb_pkg::TimeOne[16:0];
         rsp_normal_x_in = saabb_pkg::NormNone;
         rsp_normal_y_in = saabb_pkg::NormNone;
      end else if (xin > yin) begin
         rsp_hit_time_in = entry[16:0];
         rsp_normal_x_in = st_ff.gx_neg ? saabb_pkg::NormPos : saabb_pkg::NormNeg;
         rsp_normal_y_in = saabb_pkg::NormNone;
      end else begin
         // ties go to the y face
         rsp_hit_time_in = entry[16:0];
         rsp_normal_x_in = saabb_pkg::NormNone;
         rsp_normal_y_in = st_ff.gy_neg ? saabb_pkg::NormPos : saabb_pkg::NormNeg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vt_ff;
      end
      rsp_hit_time_ff <= rsp_hit_time_in;
      rsp_normal_x_ff <= rsp_normal_x_in;
      rsp_normal_y_ff <= rsp_normal_y_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_hit_time = rsp_hit_time_ff;
   assign rsp_normal_x = rsp_normal_x_ff;
   assign rsp_normal_y = rsp_normal_y_ff;

   // ---------------- assertions ----------------
   a_one_face: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_normal_x != 2'sb00 && rsp_normal_y != 2'sb00))
      else $error("both normals set");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_hit_time <= 17'd65536)
      else $error("hit time beyond one");

   a_miss_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_normal_x == 2'sb00 && rsp_normal_y == 2'sb00)
         |-> rsp_hit_time == 17'd65536)
      else $error("miss without miss time");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(vt_ff))
      else $error("strobe without pipeline transaction");

endmodule
`default_nettype wire
